// ===== hdl/dss_pkg.sv =====
// Shared types and constants for the dominator set solver.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int BLK_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int FIELD_W     = 6;
    localparam int COUNT_FW    = 7;
    localparam int SET_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CMD_W       = 2;

    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [SET_W-1:0] set_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_SOLVE    = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BLOCK = 2'd1;

    typedef struct packed {
        logic add;
        logic clear;
        logic rd;
        blk_t pred;
        blk_t addr;
    } edge_req_t;

endpackage

// ===== hdl/dss_edge_store.sv =====
// Predecessor matrix: one row per block, row valid bits, read-modify-write edge insert.
`timescale 1ns / 1ps

module dss_edge_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  dss_pkg::edge_req_t  req,
    output dss_pkg::set_t       row
);
    import dss_pkg::*;

    set_t                  mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [MAX_BLOCKS-1:0] valid_next;
    set_t                  rd_data_reg;
    logic                  rd_valid_reg;
    logic                  pend_reg;
    blk_t                  pend_addr_reg;
    blk_t                  pend_pred_reg;
    set_t                  wr_data;

    assign row     = rd_valid_reg ? rd_data_reg : '0;
    assign wr_data = row | (set_t'(1) << pend_pred_reg);

    always_comb begin
        valid_next = valid_reg;
        if (req.clear) begin
            valid_next = '0;
        end else if (pend_reg) begin
            valid_next[pend_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            pend_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= req.add;
            if (req.add || req.rd) begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.add) begin
            pend_addr_reg <= req.addr;
            pend_pred_reg <= req.pred;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            mem[pend_addr_reg] <= wr_data;
        end
        if (req.add || req.rd) begin
            rd_data_reg <= mem[req.addr];
        end
    end

endmodule

// ===== hdl/dominator_set_solver.sv =====
// Dominator set solver top level: command intake, fixed-point sweep sequencer, result output.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  s_       | s_valid / s_ready  | s_command, s_pred_block, s_succ_block
//  m_       | m_valid / m_ready  | m_block_index, m_dominators, m_last
//  cfg_     | cfg_wr_en          | cfg_index, cfg_wdata (no read-back)
//
// Solve writes each block's initial set, then sweeps: each non-entry block ANDs in the sets
// of its predecessors in use (one AND unit, one dom set memory read port); the entry block
// is skipped. Sweeps repeat until one changes nothing, then results go out in block order.
// Reset is synchronous, active low; edges and config return to reset.
// s_ready is low while a command is in progress; a stalled result holds the sequencer.
`timescale 1ns / 1ps

module dominator_set_solver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dss_pkg::CMD_W-1:0]         s_command,
    input  logic [dss_pkg::FIELD_W-1:0]       s_pred_block,
    input  logic [dss_pkg::FIELD_W-1:0]       s_succ_block,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dss_pkg::FIELD_W-1:0]       m_block_index,
    output logic [dss_pkg::SET_W-1:0]         m_dominators,
    output logic                              m_last,
    input  logic                              cfg_wr_en,
    input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dss_pkg::COUNT_FW-1:0]      cfg_wdata
);
    import dss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EDGE  = 10'b0000000010,
        S_INIT  = 10'b0000000100,
        S_ROW   = 10'b0000001000,
        S_ROWW  = 10'b0000010000,
        S_SCAN  = 10'b0000100000,
        S_DRAIN = 10'b0001000000,
        S_UPD   = 10'b0010000000,
        S_ERD   = 10'b0100000000,
        S_ELD   = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_FW-1:0]  bc_reg;
    logic [FIELD_W-1:0]   entry_reg;
    logic [CNT_W-1:0]     n_reg, n_next;
    blk_t                 nm1_reg, nm1_next;
    set_t                 all_reg, all_next;
    blk_t                 i_reg, i_next;
    blk_t                 p_reg, p_next;
    blk_t                 p_d_reg;
    logic                 scan_v_reg;
    set_t                 preds_reg, preds_next;
    set_t                 cur_reg, cur_next;
    set_t                 acc_reg, acc_next;
    logic                 changed_reg, changed_next;
    logic                 m_valid_reg, m_valid_next;
    blk_t                 m_idx_reg;
    set_t                 m_dom_reg;
    logic                 m_last_reg;
    logic                 m_load;

    set_t                 dom_mem [MAX_BLOCKS];
    set_t                 dom_rd_reg;
    logic                 dom_rd_en;
    blk_t                 dom_rd_addr;
    logic                 dom_wr_en;
    set_t                 dom_wr_data;

    edge_req_t            ereq;
    set_t                 row;

    logic                 accept;
    logic [CNT_W-1:0]     n_calc;
    set_t                 all_calc;
    logic                 i_last;
    logic                 is_entry;
    set_t                 upd_set;
    logic                 upd_diff;
    logic                 edge_ok;

    dss_edge_store u_edges (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ereq),
        .row     (row)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_block_index = FIELD_W'(m_idx_reg);
    assign m_dominators  = m_dom_reg;
    assign m_last        = m_last_reg;

    assign i_last   = (i_reg == nm1_reg);
    assign is_entry = (FIELD_W'(i_reg) == entry_reg);
    assign upd_set  = (acc_reg & cur_reg) | (set_t'(1) << i_reg);
    assign upd_diff = (upd_set != cur_reg);
    assign edge_ok  = (COUNT_FW'(s_pred_block) < COUNT_FW'(MAX_BLOCKS)) &&
                      (COUNT_FW'(s_succ_block) < COUNT_FW'(MAX_BLOCKS));

    always_comb begin
        if (bc_reg == '0) begin
            n_calc = CNT_W'(1);
        end else if (bc_reg > COUNT_FW'(MAX_BLOCKS)) begin
            n_calc = CNT_W'(MAX_BLOCKS);
        end else begin
            n_calc = CNT_W'(bc_reg);
        end
        if (32'(n_calc) >= SET_W) begin
            all_calc = '1;
        end else begin
            all_calc = (set_t'(1) << n_calc) - set_t'(1);
        end
    end

    always_comb begin
        ereq       = '0;
        ereq.pred  = blk_t'(s_pred_block);
        ereq.addr  = blk_t'(s_succ_block);
        if (accept) begin
            case (s_command)
                CMD_ADD_EDGE: ereq.add   = edge_ok;
                CMD_CLEAR:    ereq.clear = 1'b1;
                default:      ereq.add   = 1'b0;
            endcase
        end
        if (state_reg == S_ROW) begin
            ereq.rd   = 1'b1;
            ereq.addr = i_reg;
        end
    end

    always_comb begin
        dom_rd_en   = (state_reg == S_ROW) || (state_reg == S_SCAN) || (state_reg == S_ERD);
        dom_rd_addr = (state_reg == S_SCAN) ? p_reg : i_reg;
        dom_wr_en   = (state_reg == S_INIT) || ((state_reg == S_UPD) && upd_diff);
        dom_wr_data = (state_reg == S_INIT) ?
                      (is_entry ? (set_t'(1) << i_reg) : all_reg) : upd_set;
    end

    assign m_load = (state_reg == S_ELD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        all_next     = all_reg;
        i_next       = i_reg;
        p_next       = p_reg;
        preds_next   = preds_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        changed_next = changed_reg;
        m_valid_next = m_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        if (scan_v_reg && preds_reg[p_d_reg]) begin
            acc_next = acc_reg & dom_rd_reg;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_ADD_EDGE: state_next = S_EDGE;
                        CMD_SOLVE: begin
                            n_next     = n_calc;
                            nm1_next   = blk_t'(n_calc - CNT_W'(1));
                            all_next   = all_calc;
                            i_next     = '0;
                            state_next = S_INIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_EDGE: state_next = S_IDLE;
            S_INIT: begin
                if (i_last) begin
                    i_next       = '0;
                    changed_next = 1'b0;
                    state_next   = S_ROW;
                end else begin
                    i_next = i_reg + blk_t'(1);
                end
            end
            S_ROW, S_UPD: begin
                if (state_reg == S_ROW && !is_entry) begin
                    state_next = S_ROWW;
                end else begin
                    if (i_last) begin
                        i_next = '0;
                        if (changed_reg || (state_reg == S_UPD && upd_diff)) begin
                            changed_next = 1'b0;
                            state_next   = S_ROW;
                        end else begin
                            changed_next = 1'b0;
                            state_next   = S_ERD;
                        end
                    end else begin
                        if (state_reg == S_UPD && upd_diff) begin
                            changed_next = 1'b1;
                        end
                        i_next     = i_reg + blk_t'(1);
                        state_next = S_ROW;
                    end
                end
            end
            S_ROWW: begin
                cur_next   = dom_rd_reg;
                preds_next = row & all_reg;
                acc_next   = all_reg;
                p_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (p_reg == nm1_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    p_next = p_reg + blk_t'(1);
                end
            end
            S_DRAIN: state_next = S_UPD;
            S_ERD:   state_next = S_ELD;
            S_ELD: begin
                if (m_load) begin
                    if (i_last) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + blk_t'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bc_reg      <= COUNT_FW'(1);
            entry_reg   <= '0;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            scan_v_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            changed_reg <= changed_next;
            m_valid_reg <= m_valid_next;
            scan_v_reg  <= (state_reg == S_SCAN);
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BLOCK_COUNT: bc_reg    <= cfg_wdata;
                    CFG_ENTRY_BLOCK: entry_reg <= cfg_wdata[FIELD_W-1:0];
                    default:         bc_reg    <= bc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        nm1_reg   <= nm1_next;
        all_reg   <= all_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        p_d_reg   <= p_reg;
        preds_reg <= preds_next;
        cur_reg   <= cur_next;
        acc_reg   <= acc_next;
        if (m_load) begin
            m_idx_reg  <= i_reg;
            m_dom_reg  <= dom_rd_reg;
            m_last_reg <= i_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (dom_wr_en) begin
            dom_mem[i_reg] <= dom_wr_data;
        end
        if (dom_rd_en) begin
            dom_rd_reg <= dom_mem[dom_rd_addr];
        end
    end

`ifndef SYNTH
    a_update_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> ((upd_set & ~cur_reg) == '0))
        else $error("dominator set grew during a sweep");

    a_emit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ERD) |-> !changed_reg)
        else $error("emitting while a sweep still reported a change");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_ELD))
        else $error("result raised outside the emit phase");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CNT_W'(p_reg) < n_reg))
        else $error("predecessor scan beyond blocks in use");
`endif

endmodule
